/* rtl/core/ptrf_pkg.sv */
// Shared types and constants of the pulse tachometer rpm filter.
`default_nettype none

package ptrf_pkg;

  // Default build parameters
  localparam int TIMESTAMP_BITS_DEF    = 32;
  localparam int RPM_FRACTION_BITS_DEF = 8;

  // Field widths
  localparam int TS_IN_W  = 32;
  localparam int PPR_W    = 8;
  localparam int ALPHA_W  = 9;
  localparam int PER_W    = 20;
  localparam int TMO_W    = 16;
  localparam int MRPM_W   = 16;
  localparam int OUT_W    = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;
  localparam int DEN_W    = PER_W + PPR_W;

  // rpm = RPM_BASE * 2^frac / (period_us * ppr)
  localparam int unsigned RPM_BASE   = 60_000_000;
  localparam int          RPM_BASE_W = $clog2(RPM_BASE + 1);

  localparam logic [OUT_W-1:0]   OUT_MAX   = '1;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_PPR     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RPM = 3'd5;

  // Register reset values
  localparam logic [PPR_W-1:0]   RST_PPR     = 8'd1;
  localparam logic [ALPHA_W-1:0] RST_ALPHA   = 9'd26;
  localparam logic [PER_W-1:0]   RST_MIN_PER = 20'd500;
  localparam logic [PER_W-1:0]   RST_MAX_PER = 20'd100000;
  localparam logic [TMO_W-1:0]   RST_TIMEOUT = 16'd1000;
  localparam logic [MRPM_W-1:0]  RST_MAX_RPM = 16'd15000;

  // Controller -> datapath
  typedef struct packed {
    logic load;        // latch the incoming word
    logic edge_upd;    // pulse edge: measure and window check
    logic poll_start;  // poll with held period: form divisor, stamp time
    logic tmo_chk;     // poll without held period: timeout check
    logic div_init;
    logic div_step;
    logic clamp;
    logic fmul_new;
    logic fmul_old;
    logic filt;
    logic out_load;
  } ptrf_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_poll;
    logic pending;
    logic div_last;
  } ptrf_sts_t;

endpackage

`default_nettype wire

/* rtl/core/ptrf_ctrl.sv */
// Sequencing state machine of the pulse tachometer rpm filter.
`default_nettype none

module ptrf_ctrl
  import ptrf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      out_stall_i,
  input  wire ptrf_sts_t sts_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  output ptrf_cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_DIVI  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_CLAMP = 4'd4;
  localparam logic [3:0] S_FMUL1 = 4'd5;
  localparam logic [3:0] S_FMUL2 = 4'd6;
  localparam logic [3:0] S_FILT  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_q, state_d;
  logic       oval_q, oval_d;
  logic       out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = oval_q;
  assign out_free    = !oval_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts_i.is_poll) begin
          cmd_o.edge_upd = 1'b1;
          state_d        = S_DONE;
        end else if (sts_i.pending) begin
          cmd_o.poll_start = 1'b1;
          state_d          = S_DIVI;
        end else begin
          cmd_o.tmo_chk = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_DIVI: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = S_FMUL1;
      end
      S_FMUL1: begin
        cmd_o.fmul_new = 1'b1;
        state_d        = S_FMUL2;
      end
      S_FMUL2: begin
        cmd_o.fmul_old = 1'b1;
        state_d        = S_FILT;
      end
      S_FILT: begin
        cmd_o.filt = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    oval_d = oval_q;
    if (cmd_o.out_load) begin
      oval_d = 1'b1;
    end else if (oval_q && !out_stall_i) begin
      oval_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ptrf_dp.sv */
// Datapath of the pulse tachometer rpm filter: registers, divider, filter.
`default_nettype none

module ptrf_dp
  import ptrf_pkg::*;
#(
  parameter int TIMESTAMP_BITS    = TIMESTAMP_BITS_DEF,
  parameter int RPM_FRACTION_BITS = RPM_FRACTION_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ptrf_cmd_t            cmd_i,
  output ptrf_sts_t                 sts_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  input  wire logic                 req_type_i,
  input  wire logic [TS_IN_W-1:0]   time_us_i,
  input  wire logic [TS_IN_W-1:0]   time_ms_i,
  output logic [OUT_W-1:0]          rpm_q8_o,
  output logic                      rpm_valid_o,
  output logic                      edge_accepted_o
);

  localparam int TW     = TIMESTAMP_BITS;
  localparam int CW     = (TW > PER_W) ? TW : PER_W;
  localparam int NUM_W  = RPM_BASE_W + RPM_FRACTION_BITS;
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam int PROD_W = ALPHA_W + OUT_W;
  localparam logic [NUM_W-1:0] NUMER = NUM_W'(RPM_BASE) << RPM_FRACTION_BITS;

  // Configuration
  logic [PPR_W-1:0]   ppr_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic [PER_W-1:0]   min_per_q, max_per_q;
  logic [TMO_W-1:0]   timeout_q;
  logic [MRPM_W-1:0]  max_rpm_q;

  // Measurement state
  logic [TW-1:0]    last_edge_q, last_acc_q;
  logic [PER_W-1:0] held_q;
  logic             pend_q, primed_q, valid_q;
  logic [OUT_W-1:0] filt_q;

  // Working registers
  logic             poll_q, acc_q;
  logic [TW-1:0]    now_us_q, now_ms_q;
  logic [DEN_W-1:0] den_q, rem_q;
  logic [NUM_W-1:0] dq_q;
  logic [CNT_W-1:0] cnt_q;
  logic [OUT_W-1:0] raw_q;
  logic [PROD_W-1:0] pnew_q, pold_q;

  // Edge window
  logic [TW-1:0] period;
  logic [CW-1:0] period_w;
  logic          in_window;

  assign period    = now_us_q - last_edge_q;
  assign period_w  = CW'(period);
  assign in_window = (period_w > CW'(min_per_q)) && (period_w < CW'(max_per_q));

  // Timeout
  logic [TW-1:0] elapsed;
  logic          timed_out;

  assign elapsed   = now_ms_q - last_acc_q;
  assign timed_out = (elapsed > TW'(timeout_q)) && valid_q;

  // Divisor
  logic [PPR_W-1:0] ppr_eff;
  logic [DEN_W-1:0] den_prod;

  assign ppr_eff  = (ppr_q == '0) ? PPR_W'(1) : ppr_q;
  assign den_prod = DEN_W'(held_q) * DEN_W'(ppr_eff);

  // Restoring divider, one quotient bit per cycle
  logic [DEN_W:0]   rem_sh, rem_sub;
  logic             q_bit;
  logic [DEN_W-1:0] rem_nxt;

  assign rem_sh  = {rem_q, dq_q[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign q_bit   = (rem_sh >= {1'b0, den_q});
  assign rem_nxt = q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];

  // Clamp
  logic [NUM_W-1:0] lim, clamped;
  logic [OUT_W-1:0] raw_d;

  assign lim     = NUM_W'(max_rpm_q) << RPM_FRACTION_BITS;
  assign clamped = (dq_q > lim) ? lim : dq_q;
  assign raw_d   = (clamped > NUM_W'(OUT_MAX)) ? OUT_MAX : clamped[OUT_W-1:0];

  // Filter
  logic [ALPHA_W-1:0] a_eff, a_inv;
  logic [PROD_W:0]    psum;

  assign a_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  assign a_inv = ALPHA_ONE - a_eff;
  assign psum  = {1'b0, pnew_q} + {1'b0, pold_q};

  assign sts_o.is_poll  = poll_q;
  assign sts_o.pending  = pend_q;
  assign sts_o.div_last = (cnt_q == CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q       <= RST_PPR;
      alpha_q     <= RST_ALPHA;
      min_per_q   <= RST_MIN_PER;
      max_per_q   <= RST_MAX_PER;
      timeout_q   <= RST_TIMEOUT;
      max_rpm_q   <= RST_MAX_RPM;
      last_edge_q <= '0;
      last_acc_q  <= '0;
      held_q      <= '0;
      pend_q      <= 1'b0;
      primed_q    <= 1'b0;
      valid_q     <= 1'b0;
      filt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_PPR:     ppr_q     <= cfg_data_i[PPR_W-1:0];
          REG_ALPHA:   alpha_q   <= cfg_data_i[ALPHA_W-1:0];
          REG_MIN_PER: min_per_q <= cfg_data_i[PER_W-1:0];
          REG_MAX_PER: max_per_q <= cfg_data_i[PER_W-1:0];
          REG_TIMEOUT: timeout_q <= cfg_data_i[TMO_W-1:0];
          REG_MAX_RPM: max_rpm_q <= cfg_data_i[MRPM_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.edge_upd) begin
        last_edge_q <= now_us_q;
        if (in_window) begin
          held_q <= period_w[PER_W-1:0];
          pend_q <= 1'b1;
        end
      end
      if (cmd_i.poll_start) begin
        pend_q     <= 1'b0;
        last_acc_q <= now_ms_q;
      end
      if (cmd_i.tmo_chk && timed_out) begin
        valid_q  <= 1'b0;
        filt_q   <= '0;
        primed_q <= 1'b0;
      end
      if (cmd_i.filt) begin
        filt_q   <= primed_q ? psum[OUT_W+7:8] : raw_q;
        primed_q <= 1'b1;
        valid_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      poll_q   <= req_type_i;
      now_us_q <= TW'(time_us_i);
      now_ms_q <= TW'(time_ms_i);
      acc_q    <= 1'b0;
    end
    if (cmd_i.edge_upd) begin
      acc_q <= in_window;
    end
    if (cmd_i.poll_start) begin
      den_q <= (den_prod == '0) ? DEN_W'(1) : den_prod;
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      dq_q  <= NUMER;
      cnt_q <= CNT_W'(NUM_W);
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_nxt;
      dq_q  <= {dq_q[NUM_W-2:0], q_bit};
      cnt_q <= cnt_q - CNT_W'(1);
    end
    if (cmd_i.clamp) begin
      raw_q <= raw_d;
    end
    if (cmd_i.fmul_new) begin
      pnew_q <= PROD_W'(a_eff) * PROD_W'(raw_q);
    end
    if (cmd_i.fmul_old) begin
      pold_q <= PROD_W'(a_inv) * PROD_W'(filt_q);
    end
    if (cmd_i.out_load) begin
      rpm_q8_o        <= filt_q;
      rpm_valid_o     <= valid_q;
      edge_accepted_o <= acc_q;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pulse_tachometer_rpm_filter.sv */
// Top level of the pulse tachometer with low-pass rpm filter.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------
//  in      | sink      | in_valid_i / in_stall_o   | req_type_i, time_us_i, time_ms_i
//  out     | source    | out_valid_o / out_stall_i | rpm_q8_o, rpm_valid_o, edge_accepted_o
//  cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One word in flight at a time. A pulse edge or a poll with nothing held
// passes the execute step and then the done step, which loads its result word.
// A poll with a held period runs the execute, divider init, divider, clamp,
// filter product, filter and done steps; the restoring divider retires one
// quotient bit per cycle. The input is stalled from acceptance until the
// result enters the output register; the next word can be taken in the cycle
// after. A stalled result holds the block in its last step.
// Reset (asynchronous, active low) loads the register defaults and clears
// the measurement state; config writes are always taken.
`default_nettype none

module pulse_tachometer_rpm_filter
  import ptrf_pkg::*;
#(
  parameter int TIMESTAMP_BITS    = TIMESTAMP_BITS_DEF,
  parameter int RPM_FRACTION_BITS = RPM_FRACTION_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input words
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 req_type_i,
  input  wire logic [TS_IN_W-1:0]   time_us_i,
  input  wire logic [TS_IN_W-1:0]   time_ms_i,
  // result words
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [OUT_W-1:0]          rpm_q8_o,
  output logic                      rpm_valid_o,
  output logic                      edge_accepted_o,
  // register writes
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i
);

  ptrf_cmd_t cmd;
  ptrf_sts_t sts;

  // Registers are plain flops, so a write is always accepted.
  assign cfg_ready_o = 1'b1;

  ptrf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  ptrf_dp #(
    .TIMESTAMP_BITS    (TIMESTAMP_BITS),
    .RPM_FRACTION_BITS (RPM_FRACTION_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (req_type_i),
    .time_us_i       (time_us_i),
    .time_ms_i       (time_ms_i),
    .rpm_q8_o        (rpm_q8_o),
    .rpm_valid_o     (rpm_valid_o),
    .edge_accepted_o (edge_accepted_o)
  );

endmodule

`default_nettype wire

/* rtl/core/ptrf_chk.sv */
// Port-level checker of the pulse tachometer rpm filter and its bind.
`default_nettype none

module ptrf_chk
  import ptrf_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [OUT_W-1:0]     rpm_q8_o,
  input wire logic                 rpm_valid_o,
  input wire logic                 edge_accepted_o
);

  // Held result word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(rpm_q8_o)
      && $stable(rpm_valid_o) && $stable(edge_accepted_o))
    else $error("stalled result word changed");

  // An invalid reading always reports zero speed.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rpm_valid_o |-> rpm_q8_o == '0)
    else $error("invalid reading with nonzero rpm");

  // One word at a time: accepting a word makes the input busy.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after acceptance");

  // A result only appears out of a busy step.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word without work in progress");

endmodule

bind pulse_tachometer_rpm_filter ptrf_chk u_ptrf_chk (.*);

`default_nettype wire

/* dv/tb.sv */
// Self-checking bench for the pulse tachometer rpm filter: directed table, then random phases.
`timescale 1ns / 100ps

module tb
  import ptrf_pkg::*;
();

  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_POLL = 1'b1;

  // indexes past the register map, written to check they are ignored
  localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;

  localparam logic [63:0] RPM_NUM    = 64'(RPM_BASE) << RPM_FRACTION_BITS_DEF;
  localparam int          RAND_WORDS = 1950;
  localparam int          QUIET_MAX  = 1000;  // cycles with no handshake at all
  localparam int          TAIL_WAIT  = 60;    // outlasts a poll with a held period

  typedef struct packed {
    logic [OUT_W-1:0] rpm;
    logic             vld;
    logic             acc;
  } rpm_word_t;

  typedef enum logic [1:0] {ROW_EDGE, ROW_POLL, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          stamp;  // us for edges, ms for polls, data for writes
    logic                 typed;
    rpm_word_t            want;
  } dir_row_t;

  typedef enum {RX_OPEN, RX_SPOTTY, RX_BLOCKS} rx_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 req_type_i;
  logic [TS_IN_W-1:0]   time_us_i;
  logic [TS_IN_W-1:0]   time_ms_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [OUT_W-1:0]     rpm_q8_o;
  logic                 rpm_valid_o;
  logic                 edge_accepted_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  // typed expectation riding along with the presented input word
  logic      dir_chk;
  rpm_word_t dir_want;

  // bench copy of the registers
  logic [PPR_W-1:0]   ppr_cfg     = RST_PPR;
  logic [ALPHA_W-1:0] alpha_cfg   = RST_ALPHA;
  logic [PER_W-1:0]   min_per_cfg = RST_MIN_PER;
  logic [PER_W-1:0]   max_per_cfg = RST_MAX_PER;
  logic [TMO_W-1:0]   tmo_cfg     = RST_TIMEOUT;
  logic [MRPM_W-1:0]  mrpm_cfg    = RST_MAX_RPM;

  // bench copy of the measurement state
  logic [31:0]      edge_stamp_q  = '0;
  logic [PER_W-1:0] held_per_q    = '0;
  logic             per_pending_q = 1'b0;
  logic [31:0]      accept_ms_q   = '0;
  logic [OUT_W-1:0] filt_rpm_q    = '0;
  logic             filt_primed_q = 1'b0;
  logic             reading_ok_q  = 1'b0;

  rpm_word_t rpm_words_due[$];
  dir_row_t  dir_rows[$];
  int        err_count   = 0;
  int        quiet_count = 0;
  rpm_word_t pred_word;
  rpm_word_t due_word;

  pulse_tachometer_rpm_filter uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .time_us_i       (time_us_i),
    .time_ms_i       (time_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .rpm_q8_o        (rpm_q8_o),
    .rpm_valid_o     (rpm_valid_o),
    .edge_accepted_o (edge_accepted_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Advance the tachometer state by one input word and return the result word.
  function automatic rpm_word_t tach_predict(input logic kind, input logic [31:0] us,
                                             input logic [31:0] ms);
    rpm_word_t          w;
    logic [31:0]        per;
    logic [31:0]        gap_ms;
    logic [63:0]        den;
    logic [63:0]        raw;
    logic [63:0]        lim;
    logic [63:0]        mix;
    logic [ALPHA_W-1:0] a;
    w = '0;
    if (kind == REQ_EDGE) begin
      per = us - edge_stamp_q;  // wraps mod 2^32
      if (per > min_per_cfg && per < max_per_cfg) begin
        held_per_q    = per[PER_W-1:0];
        per_pending_q = 1'b1;
        w.acc         = 1'b1;
      end
      edge_stamp_q = us;
    end else begin
      if (per_pending_q) begin
        per_pending_q = 1'b0;
        // zero pulses per rev counts as one
        den = 64'(held_per_q) * 64'((ppr_cfg == '0) ? PPR_W'(1) : ppr_cfg);
        if (den == 64'd0) den = 64'd1;
        raw = RPM_NUM / den;
        lim = 64'(mrpm_cfg) << RPM_FRACTION_BITS_DEF;
        if (raw > lim) raw = lim;
        if (raw > 64'(OUT_MAX)) raw = 64'(OUT_MAX);
        a = (alpha_cfg > ALPHA_ONE) ? ALPHA_ONE : alpha_cfg;
        if (!filt_primed_q) begin
          filt_rpm_q    = raw[OUT_W-1:0];
          filt_primed_q = 1'b1;
        end else begin
          mix        = 64'(a) * raw + 64'(ALPHA_ONE - a) * 64'(filt_rpm_q);
          filt_rpm_q = mix[OUT_W+7:8];
        end
        accept_ms_q  = ms;
        reading_ok_q = 1'b1;
      end
      gap_ms = ms - accept_ms_q;
      // stale reading is dropped; a stale invalid reading stays as it is
      if (gap_ms > tmo_cfg && reading_ok_q) begin
        reading_ok_q  = 1'b0;
        filt_rpm_q    = '0;
        filt_primed_q = 1'b0;
      end
    end
    w.rpm = filt_rpm_q;
    w.vld = reading_ok_q;
    return w;
  endfunction

  function automatic dir_row_t mk_row(input row_kind_e kind, input logic [CFG_IDX_W-1:0] idx,
                                      input logic [31:0] stamp, input logic typed,
                                      input logic [OUT_W-1:0] rpm, input logic vld,
                                      input logic acc);
    dir_row_t r;
    r.kind  = kind;
    r.idx   = idx;
    r.stamp = stamp;
    r.typed = typed;
    r.want  = '{rpm: rpm, vld: vld, acc: acc};
    return r;
  endfunction

  // Present one input word and hold it until the block takes it.
  // Called at a rising edge; returns at the edge that accepted the word.
  task automatic send_word(input logic kind, input logic [31:0] us, input logic [31:0] ms,
                           input logic typed, input rpm_word_t want);
    req_type_i <= kind;
    time_us_i  <= us;
    time_ms_i  <= ms;
    dir_chk    <= typed;
    dir_want   <= want;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Register write, only once every result word is out and the block is quiet.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    if (in_valid_i) in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rpm_words_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: open stretches, scattered stalls, and long blocking stalls.
  initial begin : rx_stall
    rx_mode_e mode;
    int       mode_left;
    int       hold;
    logic     stall_now;
    out_stall_i = 1'b0;
    mode        = RX_OPEN;
    mode_left   = 0;
    hold        = 0;
    stall_now   = 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      case (mode)
        RX_OPEN: stall_now = 1'b0;
        RX_SPOTTY: stall_now = ($urandom_range(0, 2) == 0);
        default: begin
          if (hold == 0) begin
            stall_now = !stall_now;
            hold      = stall_now ? $urandom_range(1, 30) : $urandom_range(1, 8);
          end
          hold--;
        end
      endcase
      out_stall_i <= stall_now;
    end
  end

  // Handshake monitor: register writes and input words feed the predictor,
  // result words are checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_count++;
      if (cfg_valid_i && cfg_ready_o) begin
        quiet_count = 0;
        case (cfg_index_i)
          REG_PPR:     ppr_cfg     = cfg_data_i[PPR_W-1:0];
          REG_ALPHA:   alpha_cfg   = cfg_data_i[ALPHA_W-1:0];
          REG_MIN_PER: min_per_cfg = cfg_data_i[PER_W-1:0];
          REG_MAX_PER: max_per_cfg = cfg_data_i[PER_W-1:0];
          REG_TIMEOUT: tmo_cfg     = cfg_data_i[TMO_W-1:0];
          REG_MAX_RPM: mrpm_cfg    = cfg_data_i[MRPM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        quiet_count = 0;
        pred_word   = tach_predict(req_type_i, time_us_i, time_ms_i);
        // directed rows with a typed result override the predictor
        rpm_words_due.push_back(dir_chk ? dir_want : pred_word);
      end
      if (out_valid_o && !out_stall_i) begin
        quiet_count = 0;
        if (rpm_words_due.size() == 0) begin
          $error("result word with no expectation: rpm_q8 %0d", rpm_q8_o);
          err_count++;
        end else begin
          due_word = rpm_words_due.pop_front();
          if (rpm_q8_o !== due_word.rpm) begin
            $error("rpm_q8: expected %0d, actual %0d", due_word.rpm, rpm_q8_o);
            err_count++;
          end
          if (rpm_valid_o !== due_word.vld) begin
            $error("rpm_valid: expected %0d, actual %0d", due_word.vld, rpm_valid_o);
            err_count++;
          end
          if (edge_accepted_o !== due_word.acc) begin
            $error("edge_accepted: expected %0d, actual %0d", due_word.acc, edge_accepted_o);
            err_count++;
          end
        end
      end
      if (quiet_count >= QUIET_MAX) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin : stim
    logic [31:0]        cur_us;
    logic [31:0]        cur_ms;
    logic [31:0]        per;
    logic [31:0]        step_ms;
    logic [CFG_DAT_W-1:0] v_ppr;
    logic [CFG_DAT_W-1:0] v_alpha;
    logic [CFG_DAT_W-1:0] v_min;
    logic [CFG_DAT_W-1:0] v_max;
    logic [CFG_DAT_W-1:0] v_tmo;
    logic [CFG_DAT_W-1:0] v_mrpm;
    logic               idle_on;
    int                 sent;
    int                 phase;
    int                 phase_left;
    int                 burst_left;
    int                 r;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_EDGE;
    time_us_i   = '0;
    time_ms_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_PPR;
    cfg_data_i  = '0;
    dir_chk     = 1'b0;
    dir_want    = '0;

    // Directed table, run on the reset register values first.
    dir_rows.push_back(mk_row(ROW_POLL, '0, 32'd0, 1'b1, 24'd0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_EDGE, '0, 32'd0, 1'b1, 24'd0, 1'b0, 1'b0));
    // period equal to the minimum is a glitch
    dir_rows.push_back(mk_row(ROW_EDGE, '0, 32'd500, 1'b1, 24'd0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_EDGE, '0, 32'd1001, 1'b1, 24'd0, 1'b0, 1'b1));
    // first sample primes the filter, clamped to 15000 rpm
    dir_rows.push_back(mk_row(ROW_POLL, '0, 32'd10, 1'b1, 24'd3840000, 1'b1, 1'b0));
    // period equal to the maximum is too slow
    dir_rows.push_back(mk_row(ROW_EDGE, '0, 32'd101001, 1'b1, 24'd3840000, 1'b1, 1'b0));
    dir_rows.push_back(mk_row(ROW_EDGE, '0, 32'd201000, 1'b1, 24'd3840000, 1'b1, 1'b1));
    dir_rows.push_back(mk_row(ROW_POLL, '0, 32'd20, 1'b0, 24'd0, 1'b0, 1'b0));
    // exactly at the timeout: kept
    dir_rows.push_back(mk_row(ROW_POLL, '0, 32'd1020, 1'b0, 24'd0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_POLL, '0, 32'd1021, 1'b1, 24'd0, 1'b0, 1'b0));
    // timeout while not valid changes nothing
    dir_rows.push_back(mk_row(ROW_POLL, '0, 32'd1022, 1'b1, 24'd0, 1'b0, 1'b0));
    // zero ppr, saturated alpha, widest window, top clamp
    dir_rows.push_back(mk_row(ROW_CFG, REG_PPR, 32'd0, 1'b0, 24'd0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_CFG, REG_ALPHA, 32'd300, 1'b0, 24'd0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_CFG, REG_MIN_PER, 32'd0, 1'b0, 24'd0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_CFG, REG_MAX_PER, 32'hFFFFF, 1'b0, 24'd0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_CFG, REG_MAX_RPM, 32'hFFFF, 1'b0, 24'd0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_EDGE, '0, 32'hFFFFFFF0, 1'b1, 24'd0, 1'b0, 1'b0));
    // microsecond wrap gives a short in-window period
    dir_rows.push_back(mk_row(ROW_EDGE, '0, 32'd5, 1'b1, 24'd0, 1'b0, 1'b1));
    dir_rows.push_back(mk_row(ROW_POLL, '0, 32'hFFFFFFFF, 1'b1, 24'd16776960, 1'b1, 1'b0));
    dir_rows.push_back(mk_row(ROW_EDGE, '0, 32'd6, 1'b1, 24'd16776960, 1'b1, 1'b1));
    // millisecond wrap, no filtering at alpha 256
    dir_rows.push_back(mk_row(ROW_POLL, '0, 32'd5, 1'b1, 24'd16776960, 1'b1, 1'b0));
    dir_rows.push_back(mk_row(ROW_CFG, REG_TIMEOUT, 32'd0, 1'b0, 24'd0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_POLL, '0, 32'd6, 1'b1, 24'd0, 1'b0, 1'b0));
    // empty window: nothing gets through
    dir_rows.push_back(mk_row(ROW_CFG, REG_MIN_PER, 32'd1000, 1'b0, 24'd0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_CFG, REG_MAX_PER, 32'd1001, 1'b0, 24'd0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_EDGE, '0, 32'd1006, 1'b1, 24'd0, 1'b0, 1'b0));
    dir_rows.push_back(mk_row(ROW_EDGE, '0, 32'd2007, 1'b1, 24'd0, 1'b0, 1'b0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG:  cfg_write(dir_rows[i].idx, dir_rows[i].stamp[CFG_DAT_W-1:0]);
        ROW_EDGE: send_word(REQ_EDGE, dir_rows[i].stamp, $urandom, dir_rows[i].typed,
                            dir_rows[i].want);
        default:  send_word(REQ_POLL, $urandom, dir_rows[i].stamp, dir_rows[i].typed,
                            dir_rows[i].want);
      endcase
    end

    // Random phases, each on a fresh register setting.
    cur_us = $urandom;
    cur_ms = $urandom;
    sent   = 0;
    phase  = 0;
    while (sent < RAND_WORDS) begin
      case (phase % 5)
        2: begin  // low corner
          v_ppr   = $urandom_range(0, 1);
          v_alpha = 0;
          v_min   = 0;
          v_max   = $urandom_range(2, 5000);
          v_tmo   = 1;
          v_mrpm  = $urandom_range(0, 1);
        end
        3: begin  // high corner
          v_ppr   = 255;
          v_alpha = $urandom_range(0, 1) ? 256 : 511;
          v_min   = $urandom_range(0, 3000);
          v_max   = 20'hFFFFF;
          v_tmo   = 16'hFFFF;
          v_mrpm  = 16'hFFFF;
        end
        4: begin  // anything the data bits allow
          v_ppr   = $urandom;
          v_alpha = $urandom;
          v_min   = $urandom;
          v_max   = $urandom;
          v_tmo   = $urandom;
          v_mrpm  = $urandom;
        end
        default: begin  // plausible sensor setup
          v_ppr   = $urandom_range(1, 8);
          v_alpha = $urandom_range(0, 256);
          v_min   = $urandom_range(0, 3000);
          v_max   = v_min + $urandom_range(2, 200000);
          v_tmo   = $urandom_range(1, 3000);
          v_mrpm  = $urandom_range(1, 65535);
        end
      endcase
      cfg_write(REG_PPR, v_ppr);
      cfg_write(REG_ALPHA, v_alpha);
      cfg_write(REG_MIN_PER, v_min);
      cfg_write(REG_MAX_PER, v_max);
      cfg_write(REG_TIMEOUT, v_tmo);
      cfg_write(REG_MAX_RPM, v_mrpm);
      if (phase % 4 == 1) begin
        cfg_write(REG_NONE_LO, $urandom);
        cfg_write(REG_NONE_HI, $urandom);
      end

      idle_on    = ($urandom_range(0, 3) != 0);
      burst_left = $urandom_range(1, 12);
      phase_left = $urandom_range(80, 180);
      while (phase_left > 0 && sent < RAND_WORDS) begin
        if (idle_on) begin
          if (burst_left == 0) begin
            in_valid_i <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk_i);
            burst_left = $urandom_range(1, 12);
          end
          burst_left--;
        end
        r = $urandom_range(0, 99);
        if (r < 45) begin
          // edge with an in-window period when the window has room
          if (max_per_cfg > min_per_cfg + 1)
            per = $urandom_range(min_per_cfg + 1, max_per_cfg - 1);
          else
            per = $urandom_range(0, 3000);
          cur_us += per;
          send_word(REQ_EDGE, cur_us, $urandom, 1'b0, '0);
        end else if (r < 82) begin
          // poll, now and then right at or just past the timeout
          case ($urandom_range(0, 9))
            0:       step_ms = tmo_cfg + $urandom_range(1, 3);
            1:       step_ms = tmo_cfg;
            default: step_ms = $urandom_range(0, tmo_cfg);
          endcase
          cur_ms += step_ms;
          send_word(REQ_POLL, $urandom, cur_ms, 1'b0, '0);
        end else if (r < 92) begin
          // edge noise: window boundaries, bounce, or a jump anywhere
          case ($urandom_range(0, 5))
            0:       cur_us = $urandom;
            1:       cur_us += min_per_cfg;
            2:       cur_us += max_per_cfg;
            3:       cur_us += min_per_cfg + 1;
            4:       cur_us += max_per_cfg - 1;
            default: cur_us += $urandom_range(0, 2);
          endcase
          send_word(REQ_EDGE, cur_us, $urandom, 1'b0, '0);
        end else begin
          cur_ms = $urandom_range(0, 1) ? $urandom : cur_ms + $urandom_range(0, 70000);
          send_word(REQ_POLL, $urandom, cur_ms, 1'b0, '0);
        end
        sent++;
        phase_left--;
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rpm_words_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (err_count == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
